### rtl/core/led_panel_scan_dither_controller_defines.svh
// ----------------------------------------------------------------------------
// LED panel scan controller assertion macros
// Shared property wrappers for the port checker, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LED_PANEL_SCAN_DITHER_CONTROLLER_DEFINES_SVH
`define LED_PANEL_SCAN_DITHER_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define LPSD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpsd port check failed");

// next-cycle implication
`define LPSD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpsd port check failed");

`endif

### rtl/core/lsdc_pkg.sv
// ----------------------------------------------------------------------------
// lsdc_pkg
// Types, constants and the COM code table of the LED panel scan controller.
// ----------------------------------------------------------------------------
package lsdc_pkg;

    localparam int NumSlot  = 15;
    localparam int SegW     = 16;
    localparam int ComW     = 8;
    localparam int CurW     = 4;
    localparam int FrameW   = 28;
    localparam int LevelW   = 2;
    localparam int WordW    = 30;
    localparam int PairW    = 2;
    localparam int PosW     = 3;
    localparam int ChW      = 2;
    localparam int SlotW    = 4;
    localparam int FifoDepth = 4;
    localparam int PtrW     = 2;
    localparam int CntW     = 3;

    localparam logic [PosW-1:0]  MaxPos   = 3'd4;
    localparam logic [ChW-1:0]   MaxCh    = 2'd2;
    localparam logic [CurW-1:0]  CurReset = 4'd13;
    localparam logic [LevelW-1:0] LvlOff  = 2'd0;
    localparam logic [LevelW-1:0] LvlHalf = 2'd1;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_TICK  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        CFG_CURRENT_LEVEL = 2'd0,
        CFG_SPARE_SINK_ON = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic              en;
        logic              driver;
        logic [PairW-1:0]  com_pair;
        logic [SlotW-1:0]  slot;
        logic [LevelW-1:0] level;
    } t_store_wr;

    typedef struct packed {
        logic              bus_select;
        logic [FrameW-1:0] frame_word;
        logic              last;
    } t_frame;

    function automatic logic [ComW-1:0] com_code(input logic [PairW-1:0] pair);
        logic [ComW-1:0] code;
        case (pair)
            2'd0:    code = 8'h30;
            2'd1:    code = 8'h0C;
            2'd2:    code = 8'h03;
            default: code = 8'hC0;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/lsdc_store.sv
// ----------------------------------------------------------------------------
// lsdc_store
// Channel level store: per driver four COM pair words of fifteen 2-bit levels.
// One write port; one read per driver at the scanned COM pair.
// ----------------------------------------------------------------------------
module lsdc_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lsdc_pkg::t_store_wr              i_wr,
    input  logic [lsdc_pkg::PairW-1:0]       i_rd_pair,
    output logic [lsdc_pkg::WordW-1:0]       o_word0,
    output logic [lsdc_pkg::WordW-1:0]       o_word1
);

    logic [lsdc_pkg::WordW-1:0] r_store0 [4];
    logic [lsdc_pkg::WordW-1:0] r_store1 [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_store0[i] <= '0;
                r_store1[i] <= '0;
            end
        end else if (i_wr.en) begin
            if (i_wr.driver) begin
                r_store1[i_wr.com_pair][{i_wr.slot, 1'b0} +: lsdc_pkg::LevelW] <= i_wr.level;
            end else begin
                r_store0[i_wr.com_pair][{i_wr.slot, 1'b0} +: lsdc_pkg::LevelW] <= i_wr.level;
            end
        end
    end

    assign o_word0 = r_store0[i_rd_pair];
    assign o_word1 = r_store1[i_rd_pair];

endmodule

### rtl/core/lsdc_seg.sv
// ----------------------------------------------------------------------------
// lsdc_seg
// Segment builder for one driver: decodes fifteen channel levels into
// segment bits for the current sub-frame and flags any half level.
// ----------------------------------------------------------------------------
module lsdc_seg (
    input  logic [lsdc_pkg::WordW-1:0] i_word,
    input  logic                       i_sub,
    input  logic                       i_spare,
    output logic [lsdc_pkg::SegW-1:0]  o_seg,
    output logic                       o_half
);

    always_comb begin
        logic [lsdc_pkg::LevelW-1:0] lv;
        o_seg  = '0;
        o_half = 1'b0;
        for (int s = 0; s < lsdc_pkg::NumSlot; s++) begin
            lv = i_word[2*s +: lsdc_pkg::LevelW];
            if (lv == lsdc_pkg::LvlHalf) begin
                o_half = 1'b1;
            end
            if (lv != lsdc_pkg::LvlOff && (!i_sub || lv != lsdc_pkg::LvlHalf)) begin
                o_seg[s+1] = 1'b1;
            end
        end
        if (i_spare) begin
            o_seg[0] = 1'b1;
        end
    end

endmodule

### rtl/core/lsdc_ofifo.sv
// ----------------------------------------------------------------------------
// lsdc_ofifo
// Result queue of four frames; takes up to two frames a cycle, hands out one while the receiver is ready.
// ----------------------------------------------------------------------------
module lsdc_ofifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push0,
    input  lsdc_pkg::t_frame    i_frm0,
    input  logic                i_push1,
    input  lsdc_pkg::t_frame    i_frm1,
    output logic                o_room2,
    output logic                o_valid,
    input  logic                i_ready,
    output lsdc_pkg::t_frame    o_frm
);

    lsdc_pkg::t_frame              r_mem [lsdc_pkg::FifoDepth];
    logic [lsdc_pkg::PtrW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [lsdc_pkg::PtrW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [lsdc_pkg::CntW-1:0]     r_count, n_count;
    logic [lsdc_pkg::PtrW-1:0]     wr_ptr1;
    logic                          pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= lsdc_pkg::CntW'(lsdc_pkg::FifoDepth - 2));
    assign o_frm   = r_mem[r_rd_ptr];
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + lsdc_pkg::PtrW'(i_push0) + lsdc_pkg::PtrW'(i_push1);
        n_rd_ptr = r_rd_ptr + lsdc_pkg::PtrW'(pop);
        n_count  = r_count + lsdc_pkg::CntW'(i_push0) + lsdc_pkg::CntW'(i_push1)
                 - lsdc_pkg::CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_frm0;
        end
        if (i_push1) begin
            r_mem[wr_ptr1] <= i_frm1;
        end
    end

endmodule

### rtl/core/led_panel_scan_dither_controller.sv
// ----------------------------------------------------------------------------
// led_panel_scan_dither_controller
// Scan controller for a two-driver RGB LED panel with 3-level dithering.
//
// Input channel (i_valid/o_ready): a write item sets one channel level; a
// tick item scans the COM pair of the current phase and advances the phase.
// Output channel (o_valid/i_ready): frame words, driver 0 before driver 1,
// o_last marking the final frame of a tick. Sub-frame 1 ticks without any
// half level emit nothing.
// A tick is held in the input register, then its frames are written to the
// result queue, whose head frame drives the output. Writes pass back to
// back; every tick, empty or not, waits for room for two frames in the
// four-frame result queue, which the single-frame output port drains.
// Reset: level store cleared, phase zero, current level 13, spare sink off.
// A stalled receiver holds the head frame; the queue fills, then the input
// register holds its tick and o_ready drops. Configuration writes apply to
// ticks leaving the input register afterwards.
// ----------------------------------------------------------------------------
module led_panel_scan_dither_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [lsdc_pkg::CurW-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic                           i_driver,
    input  logic [lsdc_pkg::PairW-1:0]     i_com_pair,
    input  logic [lsdc_pkg::PosW-1:0]      i_led_pos,
    input  logic [lsdc_pkg::ChW-1:0]       i_channel,
    input  logic [lsdc_pkg::LevelW-1:0]    i_level,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_bus_select,
    output logic [lsdc_pkg::FrameW-1:0]    o_frame_word,
    output logic                           o_last
);

    logic                           r_vld;
    lsdc_pkg::t_req                 r_req;
    logic                           r_drv;
    logic [lsdc_pkg::PairW-1:0]     r_pair;
    logic [lsdc_pkg::PosW-1:0]      r_pos;
    logic [lsdc_pkg::ChW-1:0]       r_ch;
    logic [lsdc_pkg::LevelW-1:0]    r_lvl;
    logic [2:0]                     r_phase;
    logic [lsdc_pkg::CurW-1:0]      r_cur;
    logic                           r_spare;

    logic                           advance;
    logic                           in_xfer;
    logic                           is_tick;
    logic                           room2;
    lsdc_pkg::t_store_wr            store_wr;
    logic [lsdc_pkg::WordW-1:0]     word0, word1;
    logic [lsdc_pkg::SegW-1:0]      seg0, seg1;
    logic                           half0, half1;
    logic                           emit0, emit1;
    logic [lsdc_pkg::PairW-1:0]     scan_pair;
    logic                           scan_sub;
    lsdc_pkg::t_frame               frm0, frm1, push_frm0, head;
    logic                           push0, push1;

    assign scan_pair = r_phase[2:1];
    assign scan_sub  = r_phase[0];
    assign is_tick   = (r_req == lsdc_pkg::REQ_TICK);
    assign advance   = r_vld && (!is_tick || room2);
    assign o_ready   = !r_vld || advance;
    assign in_xfer   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req  <= lsdc_pkg::t_req'(i_req_type);
            r_drv  <= i_driver;
            r_pair <= i_com_pair;
            r_pos  <= i_led_pos;
            r_ch   <= i_channel;
            r_lvl  <= i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (advance && is_tick) begin
            r_phase <= r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= lsdc_pkg::CurReset;
            r_spare <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (lsdc_pkg::t_cfg_idx'(i_cfg_idx))
                lsdc_pkg::CFG_CURRENT_LEVEL: r_cur   <= i_cfg_data;
                lsdc_pkg::CFG_SPARE_SINK_ON: r_spare <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        store_wr.en       = advance && !is_tick && (r_pos <= lsdc_pkg::MaxPos)
                          && (r_ch <= lsdc_pkg::MaxCh);
        store_wr.driver   = r_drv;
        store_wr.com_pair = r_pair;
        store_wr.slot     = {r_pos, 1'b0} + {1'b0, r_pos} + {2'b00, r_ch};
        store_wr.level    = r_lvl;
    end

    lsdc_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (store_wr),
        .i_rd_pair (scan_pair),
        .o_word0   (word0),
        .o_word1   (word1)
    );

    lsdc_seg u_seg0 (
        .i_word  (word0),
        .i_sub   (scan_sub),
        .i_spare (r_spare),
        .o_seg   (seg0),
        .o_half  (half0)
    );

    lsdc_seg u_seg1 (
        .i_word  (word1),
        .i_sub   (scan_sub),
        .i_spare (r_spare),
        .o_seg   (seg1),
        .o_half  (half1)
    );

    always_comb begin
        emit0 = !scan_sub || half0;
        emit1 = !scan_sub || half1;

        frm0.bus_select = 1'b0;
        frm0.frame_word = {r_cur, lsdc_pkg::com_code(scan_pair), seg0};
        frm0.last       = !emit1;

        frm1.bus_select = 1'b1;
        frm1.frame_word = {r_cur, lsdc_pkg::com_code(scan_pair), seg1};
        frm1.last       = 1'b1;

        // compact: lone driver 1 frame goes in the first push slot
        push_frm0 = emit0 ? frm0 : frm1;
        push0     = advance && is_tick && (emit0 || emit1);
        push1     = advance && is_tick && emit0 && emit1;
    end

    lsdc_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_frm0  (push_frm0),
        .i_push1 (push1),
        .i_frm1  (frm1),
        .o_room2 (room2),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_frm   (head)
    );

    assign o_bus_select = head.bus_select;
    assign o_frame_word = head.frame_word;
    assign o_last       = head.last;

endmodule

### rtl/core/lsdc_checker.sv
// ----------------------------------------------------------------------------
// lsdc_checker
// Port-level checks on the result channel of the LED panel scan controller.
// ----------------------------------------------------------------------------
`include "led_panel_scan_dither_controller_defines.svh"

module lsdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_bus_select,
    input logic [27:0] o_frame_word,
    input logic        o_last
);

    `LPSD_ASSERT_NXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_frame_word) && $stable(o_bus_select) && $stable(o_last))

    `LPSD_ASSERT_IMP(a_nonlast_is_drv0, o_valid && !o_last, !o_bus_select)

    `LPSD_ASSERT_IMP(a_drv1_is_last, o_valid && o_bus_select, o_last)

    `LPSD_ASSERT_IMP(a_com_code, o_valid,
        o_frame_word[23:16] == 8'h30 || o_frame_word[23:16] == 8'h0C ||
        o_frame_word[23:16] == 8'h03 || o_frame_word[23:16] == 8'hC0)

    `LPSD_ASSERT_NXT(a_pair_follows, o_valid && i_ready && !o_last,
        o_valid && o_bus_select && $stable(o_frame_word[23:16]))

endmodule

bind led_panel_scan_dither_controller lsdc_checker u_lsdc_checker (.*);
